/* rtl/core/agsdm_pkg.sv */
// Shared types and constants for the gain / soft-clip / downmix block.
// Depends on nothing; imported by agsdm_shaper and audio_gain_soft_clip_downmix.
package agsdm_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int GAIN_BITS     = 16;
  localparam int GAIN_FRAC_DEF = 12;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_SILENCE = 2'd1,
    MODE_PASS    = 2'd2,
    MODE_GAIN    = 2'd3
  } mode_t;

  localparam logic [CFG_IDX_BITS-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_STEREO = 2'd2;

  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd4096;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] src_left;
    logic signed [SAMPLE_BITS-1:0] src_right;
    logic                          src_valid;
    logic signed [SAMPLE_BITS-1:0] host_left;
    logic signed [SAMPLE_BITS-1:0] host_right;
    logic                          host_present;
    logic                          last_frame;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
    logic [1:0]                    channel_count;
    logic                          last_frame_out;
  } out_word_t;

endpackage

/* rtl/core/agsdm_shaper.sv */
// One channel of gain and soft-knee clipping, fully pipelined.
// Knee curve uses a restoring divider, one quotient bit per stage. Depends on agsdm_pkg.
module agsdm_shaper #(
  parameter int GAIN_FRAC_BITS = agsdm_pkg::GAIN_FRAC_DEF
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [agsdm_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [agsdm_pkg::GAIN_BITS-1:0]          gain,
  output logic signed [agsdm_pkg::SAMPLE_BITS-1:0] shaped
);
  import agsdm_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int QB = SB - 2;
  localparam int AW = SB + GAIN_BITS - 1 - GAIN_FRAC_BITS;
  localparam int DW = AW + 1;
  localparam int PW = SB + GAIN_BITS;

  localparam logic [63:0] ONE_L  = 64'd1 << (SB - 1);
  localparam logic [63:0] KNEE_L = (ONE_L * 64'd17 + 64'd10) / 64'd20;
  localparam logic [63:0] HEAD_L = ONE_L - KNEE_L;
  localparam logic [63:0] NUM_L  = HEAD_L * HEAD_L;

  localparam logic [2*QB-1:0] NUM    = NUM_L[2*QB-1:0];
  localparam logic [DW-1:0]   REM0   = DW'(NUM_L >> QB);
  localparam logic [AW-1:0]   KNEE_A = AW'(KNEE_L);
  localparam logic [DW-1:0]   KNEE_D = DW'(KNEE_L);
  localparam logic [DW-1:0]   HEAD_D = DW'(HEAD_L);
  localparam logic [SB-1:0]   ONE_S  = SB'(ONE_L);

  // stage 1: magnitude
  logic [SB-1:0] mag1;
  logic          neg1;
  // stage 2: gained magnitude
  logic [AW-1:0] a2;
  logic          neg2;
  logic [PW-1:0] prod;

  logic [DW-1:0]   d_den  [0:QB];
  logic            d_lin  [0:QB];
  logic [SB-2:0]   d_ylin [0:QB];
  logic            d_neg  [0:QB];
  logic [DW-1:0]   d_rem  [1:QB];
  logic [QB-1:0]   d_q    [1:QB];

  logic [SB-2:0] ceil_q;
  logic [SB-1:0] curve;
  logic [SB-2:0] y;

  assign prod = PW'(mag1) * PW'(gain);

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= sample[SB-1];
      mag1 <= sample[SB-1] ? SB'(-sample) : SB'(sample);
      neg2 <= neg1;
      a2   <= prod[GAIN_FRAC_BITS +: AW];
      d_neg[0]  <= neg2;
      d_lin[0]  <= (a2 <= KNEE_A);
      d_ylin[0] <= a2[SB-2:0];
      d_den[0]  <= {1'b0, a2} + HEAD_D - KNEE_D;
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_div
    logic [DW-1:0] rem_in;
    logic [QB-1:0] q_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          take;

    if (i == 0) begin : g_first
      assign rem_in = REM0;
      assign q_in   = '0;
    end else begin : g_rest
      assign rem_in = d_rem[i];
      assign q_in   = d_q[i];
    end

    assign trial = {rem_in, NUM[QB-1-i]};
    assign diff  = trial - {1'b0, d_den[i]};
    assign take  = ~diff[DW];

    always_ff @(posedge clk) begin
      if (en) begin
        d_rem[i+1]  <= take ? diff[DW-1:0] : trial[DW-1:0];
        d_q[i+1]    <= {q_in[QB-2:0], take};
        d_den[i+1]  <= d_den[i];
        d_lin[i+1]  <= d_lin[i];
        d_ylin[i+1] <= d_ylin[i];
        d_neg[i+1]  <= d_neg[i];
      end
    end
  end

  // knee region: y = ONE - ceil(H*H / (H + d))
  assign ceil_q = {1'b0, d_q[QB]} + (SB-1)'(d_rem[QB] != '0);
  assign curve  = ONE_S - {1'b0, ceil_q};
  assign y      = d_lin[QB] ? d_ylin[QB] : curve[SB-2:0];

  always_ff @(posedge clk) begin
    if (en) begin
      shaped <= d_neg[QB] ? $signed(-{1'b0, y}) : $signed({1'b0, y});
    end
  end

endmodule

/* rtl/core/audio_gain_soft_clip_downmix.sv */
// Top level: config registers, frame pipeline, mode select and mono downmix.
// Depends on agsdm_pkg and agsdm_shaper.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   in      | in_valid, in_ready, in_data      | word in
//   out     | out_valid, out_ready, out_data   | word out
//   cfg     | cfg_we, cfg_idx, cfg_data        | register write
//
// One word per cycle sustained while the output is not stalled; the depth is set by the
// bit-per-stage divider of the knee curve. The whole pipeline advances when the
// output register is empty or taken, so a stall holds every stage in place.
// Reset clears valid bits and loads mode off, gain 4096 (1.0 at the default 12 fraction bits), stereo output.
module audio_gain_soft_clip_downmix #(
  parameter int GAIN_FRAC_BITS = agsdm_pkg::GAIN_FRAC_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  agsdm_pkg::in_word_t                   in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output agsdm_pkg::out_word_t                  out_data,
  input  logic                                  cfg_we,
  input  logic [agsdm_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
  input  logic [agsdm_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import agsdm_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int LAT = SB + 2;

  typedef struct packed {
    logic signed [SB-1:0] host_left;
    logic signed [SB-1:0] host_right;
    logic                 host_present;
    logic                 src_valid;
    logic                 last_frame;
  } ctl_t;

  mode_t                mode;
  logic [GAIN_BITS-1:0] gain;
  logic                 stereo_out;

  logic                 en;
  logic                 vld [0:LAT-1];
  ctl_t                 ctl [0:LAT-1];
  logic signed [SB-1:0] yl;
  logic signed [SB-1:0] yr;

  logic signed [SB-1:0] l_next;
  logic signed [SB-1:0] r_next;
  logic signed [SB:0]   sum;
  logic signed [SB:0]   sum_adj;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_OFF;
      gain       <= GAIN_RESET;
      stereo_out <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MODE:   mode       <= mode_t'(cfg_data[1:0]);
        REG_GAIN:   gain       <= cfg_data[GAIN_BITS-1:0];
        REG_STEREO: stereo_out <= cfg_data[0];
        default: ;
      endcase
    end
  end

  agsdm_shaper #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_shp_l (
    .clk    (clk),
    .en     (en),
    .sample (in_data.src_left),
    .gain   (gain),
    .shaped (yl)
  );

  agsdm_shaper #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_shp_r (
    .clk    (clk),
    .en     (en),
    .sample (in_data.src_right),
    .gain   (gain),
    .shaped (yr)
  );

  // side data and valid bits, aligned with the shapers
  always_ff @(posedge clk) begin
    if (en) begin
      ctl[0] <= '{host_left:    in_data.host_left,
                  host_right:   in_data.host_right,
                  host_present: in_data.host_present,
                  src_valid:    in_data.src_valid,
                  last_frame:   in_data.last_frame};
      for (int i = 1; i < LAT; i++) begin
        ctl[i] <= ctl[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < LAT; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  // mono average, rounded toward zero
  assign sum     = {yl[SB-1], yl} + {yr[SB-1], yr};
  assign sum_adj = sum + (SB+1)'(sum[SB]);

  always_comb begin
    l_next = '0;
    r_next = '0;
    case (mode)
      MODE_PASS: begin
        if (ctl[LAT-1].host_present) begin
          l_next = ctl[LAT-1].host_left;
          r_next = ctl[LAT-1].host_right;
        end
      end
      MODE_GAIN: begin
        if (gain != '0 && ctl[LAT-1].src_valid) begin
          l_next = stereo_out ? yl : sum_adj[SB:1];
          r_next = yr;
        end
      end
      default: ;
    endcase
    if (!stereo_out) begin
      r_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.out_left       <= l_next;
      out_data.out_right      <= r_next;
      out_data.channel_count  <= stereo_out ? 2'd2 : 2'd1;
      out_data.last_frame_out <= ctl[LAT-1].last_frame;
    end
  end

endmodule
